// ----- rtl/htte_pkg.sv -----
// ----------------------------------------------------------------------------
// htte_pkg
// Shared types, constants and tag tables of the HTML tagged text extractor.
// ----------------------------------------------------------------------------
package htte_pkg;

    localparam int DIV_TAG_LEN   = 20;
    localparam int P_TAG_LEN     = 3;
    localparam int SHORT_TAG_LEN = 4;
    localparam int COUNT_MAX     = 31;

    localparam logic [7:0] CHAR_NL = 8'h0A;
    localparam logic [7:0] CHAR_LT = 8'h3C;
    localparam logic [7:0] CHAR_GT = 8'h3E;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    typedef enum logic [1:0] {
        PH_DIV  = 2'd0,
        PH_P    = 2'd1,
        PH_TEXT = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t      search_phase;
        logic        inside_tag;
        logic [4:0]  tag_count;
        logic        match_first;
        logic        match_second;
    } scan_state_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  text_byte;
        logic        text_end;
    } scan_result_t;

    localparam scan_state_t SCAN_STATE_RESET = '{
        search_phase: PH_DIV,
        inside_tag:   1'b0,
        tag_count:    5'd0,
        match_first:  1'b0,
        match_second: 1'b0
    };

    // Characters of <div class="lyrics">.
    function automatic logic [7:0] div_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "<";
            5'd1:    c = "d";
            5'd2:    c = "i";
            5'd3:    c = "v";
            5'd4:    c = " ";
            5'd5:    c = "c";
            5'd6:    c = "l";
            5'd7:    c = "a";
            5'd8:    c = "s";
            5'd9:    c = "s";
            5'd10:   c = "=";
            5'd11:   c = 8'h22;
            5'd12:   c = "l";
            5'd13:   c = "y";
            5'd14:   c = "r";
            5'd15:   c = "i";
            5'd16:   c = "c";
            5'd17:   c = "s";
            5'd18:   c = 8'h22;
            5'd19:   c = ">";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Characters of <p>.
    function automatic logic [7:0] p_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = "<";
            2'd1:    c = "p";
            2'd2:    c = ">";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Characters of <br>.
    function automatic logic [7:0] br_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = "<";
            2'd1:    c = "b";
            2'd2:    c = "r";
            default: c = ">";
        endcase
        return c;
    endfunction

    // Characters of </p>.
    function automatic logic [7:0] endp_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = "<";
            2'd1:    c = "/";
            2'd2:    c = "p";
            default: c = ">";
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/htte_step.sv -----
// ----------------------------------------------------------------------------
// htte_step
// Next-state and result logic for one document byte.
// ----------------------------------------------------------------------------
module htte_step (
    input  htte_pkg::scan_state_t  cur_state,
    input  logic [7:0]             doc_byte,
    input  logic                   doc_start,
    output htte_pkg::scan_state_t  next_state,
    output htte_pkg::scan_result_t result
);
    import htte_pkg::*;

    scan_state_t st;
    logic [4:0]  seek_len;
    logic [7:0]  seek_char;
    logic        seek_match;
    logic [4:0]  seek_count;
    logic        txt_mf0;
    logic        txt_ms0;
    logic [4:0]  txt_c0;
    logic        txt_mf1;
    logic        txt_ms1;
    logic [4:0]  txt_c1;

    always_comb begin
        st = doc_start ? SCAN_STATE_RESET : cur_state;
        next_state = st;
        result.valid     = 1'b0;
        result.text_byte = doc_byte;
        result.text_end  = 1'b0;

        seek_len   = (st.search_phase == PH_DIV) ? 5'(DIV_TAG_LEN) : 5'(P_TAG_LEN);
        seek_char  = (st.search_phase == PH_DIV) ? div_char(st.tag_count)
                                                 : p_char(st.tag_count[1:0]);
        seek_match = st.match_first && (doc_byte == seek_char);
        seek_count = st.tag_count + 5'd1;

        txt_mf0 = st.inside_tag ? st.match_first  : 1'b1;
        txt_ms0 = st.inside_tag ? st.match_second : 1'b1;
        txt_c0  = st.inside_tag ? st.tag_count    : 5'd0;
        if (txt_c0 < 5'(SHORT_TAG_LEN)) begin
            txt_mf1 = txt_mf0 && (doc_byte == br_char(txt_c0[1:0]));
            txt_ms1 = txt_ms0 && (doc_byte == endp_char(txt_c0[1:0]));
        end else begin
            txt_mf1 = 1'b0;
            txt_ms1 = 1'b0;
        end
        txt_c1 = (txt_c0 < 5'(COUNT_MAX)) ? txt_c0 + 5'd1 : txt_c0;

        if (doc_byte != CHAR_NL) begin
            case (st.search_phase)
                PH_DIV, PH_P: begin
                    if (!st.inside_tag) begin
                        if (doc_byte == CHAR_LT) begin
                            next_state.inside_tag  = 1'b1;
                            next_state.tag_count   = 5'd1;
                            next_state.match_first = 1'b1;
                        end
                    end else if (st.tag_count >= seek_len) begin
                        // The tag grew too long; it is dropped with this byte.
                        next_state = SCAN_STATE_RESET;
                        next_state.search_phase = st.search_phase;
                    end else if (seek_match && (seek_count == seek_len)) begin
                        next_state = SCAN_STATE_RESET;
                        next_state.search_phase =
                            (st.search_phase == PH_DIV) ? PH_P : PH_TEXT;
                    end else if (doc_byte == CHAR_GT) begin
                        next_state = SCAN_STATE_RESET;
                        next_state.search_phase = st.search_phase;
                    end else begin
                        next_state.match_first = seek_match;
                        next_state.tag_count   = seek_count;
                    end
                end
                PH_TEXT: begin
                    if (!st.inside_tag && (doc_byte != CHAR_LT)) begin
                        result.valid = 1'b1;
                    end else if ((txt_c1 == 5'(SHORT_TAG_LEN)) && txt_mf1) begin
                        next_state = SCAN_STATE_RESET;
                        next_state.search_phase = PH_TEXT;
                        result.valid     = 1'b1;
                        result.text_byte = CHAR_NL;
                    end else if ((txt_c1 == 5'(SHORT_TAG_LEN)) && txt_ms1) begin
                        next_state = SCAN_STATE_RESET;
                        next_state.search_phase = PH_DONE;
                        result.valid     = 1'b1;
                        result.text_byte = CHAR_NUL;
                        result.text_end  = 1'b1;
                    end else if (doc_byte == CHAR_GT) begin
                        next_state = SCAN_STATE_RESET;
                        next_state.search_phase = PH_TEXT;
                    end else begin
                        next_state.inside_tag   = 1'b1;
                        next_state.tag_count    = txt_c1;
                        next_state.match_first  = txt_mf1;
                        next_state.match_second = txt_ms1;
                    end
                end
                default: begin
                    next_state = st;
                end
            endcase
        end
    end

endmodule

// ----- rtl/html_tagged_text_extractor.sv -----
// ----------------------------------------------------------------------------
// html_tagged_text_extractor
// Pulls the paragraph text of the lyrics division out of an HTML byte stream.
// ----------------------------------------------------------------------------
// The input channel (s_valid, s_ready, s_doc_byte, s_doc_start) carries one
// document byte per transaction. Set s_doc_start on the first byte of each
// document; it clears the search state before that byte is looked at.
// The result channel (m_valid, m_ready, m_text_byte, m_text_end) carries the
// extracted text: plain bytes, a newline for each <br> tag, and one final
// transaction with m_text_end high and a zero byte when </p> closes the text.
// Most input bytes produce no result at all (tags, newlines, bytes before
// the paragraph and after its end).
//
// Every byte is handled by the scan logic in the cycle it is accepted, and
// any result is loaded into the output register. The block takes one byte
// per cycle while s_ready is high. The single output register sets the rate:
// s_ready is low only while a result sits unconsumed and m_ready is low, so
// a stalled receiver holds the input side for exactly as long as it stalls.
//
// A synchronous active-low reset on aresetn clears the search phase, the
// tag tracking state and the output valid flag.
// ----------------------------------------------------------------------------
module html_tagged_text_extractor (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_doc_byte,
    input  logic       s_doc_start,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_text_byte,
    output logic       m_text_end
);
    import htte_pkg::*;

    scan_state_t  state_reg;
    scan_state_t  state_next;
    scan_result_t step_result;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_end_reg;
    logic       in_accept;

    // A new byte may enter whenever the output register is empty or is
    // being drained in this same cycle.
    assign s_ready   = !out_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    htte_step u_step (
        .cur_state  (state_reg),
        .doc_byte   (s_doc_byte),
        .doc_start  (s_doc_start),
        .next_state (state_next),
        .result     (step_result)
    );

    // The scan state only moves on an accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_STATE_RESET;
        end else if (in_accept) begin
            state_reg <= state_next;
        end
    end

    // Output register: loaded when the accepted byte yields a result,
    // emptied when the receiver takes the pending one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_accept && step_result.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset; it is only looked at while valid is high.
    always_ff @(posedge aclk) begin
        if (in_accept && step_result.valid) begin
            out_byte_reg <= step_result.text_byte;
            out_end_reg  <= step_result.text_end;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_text_byte = out_byte_reg;
    assign m_text_end  = out_end_reg;

endmodule

// ----- rtl/htte_checker.sv -----
// ----------------------------------------------------------------------------
// htte_checker
// Port-level checks of the HTML tagged text extractor, bound to the top level.
// ----------------------------------------------------------------------------
module htte_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_doc_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_text_byte,
    input logic       m_text_end
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_text_byte) && $stable(m_text_end))
        else $error("result changed while stalled");

    // The end marker always carries a zero byte.
    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_text_end |-> m_text_byte == 8'h00)
        else $error("end marker with nonzero byte");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With nothing pending the block always takes input.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // A newline byte never produces a result in the next cycle.
    a_newline_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_doc_byte == 8'h0A) |=> !m_valid)
        else $error("result from a newline byte");

endmodule

bind html_tagged_text_extractor htte_checker u_htte_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_doc_byte  (s_doc_byte),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_text_byte (m_text_byte),
    .m_text_end  (m_text_end)
);

// ----- test/html_tagged_text_extractor_test.sv -----
// ----------------------------------------------------------------------------
// html_tagged_text_extractor_test
// Self-checking testbench for the HTML tagged text extractor.
// ----------------------------------------------------------------------------
// Documents are built from random pieces: decoy and damaged tags around the
// lyrics division and paragraph tags, text with line breaks and stray tags,
// and an optional closing paragraph tag. A scoreboard follows every accepted
// input byte with its own copy of the scan state and checks each result in
// order. Both channels idle at random, and the receiver also holds off for a
// long stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module html_tagged_text_extractor_test;

    import htte_pkg::*;

    localparam string DIV_TAG  = "<div class=\"lyrics\">";
    localparam string P_TAG    = "<p>";
    localparam string BR_TAG   = "<br>";
    localparam string ENDP_TAG = "</p>";

    // One expected transaction on the result channel.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } text_item_t;

    // The scoreboard keeps its own scan state. Each accepted input byte is
    // run through it, and any text it yields is queued until the block
    // delivers the matching result transaction.
    class extract_scoreboard;
        phase_t     phase;
        bit         in_tag;
        bit [4:0]   tag_len;
        bit         tag_hit;
        bit         endp_hit;
        text_item_t text_q[$];
        int         errors;

        function new();
            phase  = PH_DIV;
            errors = 0;
            drop_tag();
        endfunction

        function void drop_tag();
            in_tag   = 1'b0;
            tag_len  = '0;
            tag_hit  = 1'b0;
            endp_hit = 1'b0;
        endfunction

        function int pending();
            return text_q.size();
        endfunction

        // Exact match of one opening tag while searching for the division
        // or the paragraph.
        function void seek_tag(logic [7:0] b, string tag);
            if (!in_tag) begin
                if (b == CHAR_LT) begin
                    in_tag  = 1'b1;
                    tag_len = 5'd1;
                    tag_hit = 1'b1;
                end
                return;
            end
            if (tag_len + 1 > tag.len()) begin
                drop_tag();
                return;
            end
            tag_hit = tag_hit && (b == tag[tag_len]);
            tag_len++;
            if (tag_hit && tag_len == tag.len()) begin
                drop_tag();
                phase = (phase == PH_DIV) ? PH_P : PH_TEXT;
                return;
            end
            if (b == CHAR_GT)
                drop_tag();
        endfunction

        function void scan_text(logic [7:0] b);
            if (!in_tag) begin
                if (b != CHAR_LT) begin
                    text_q.push_back('{b, 1'b0});
                    return;
                end
                in_tag   = 1'b1;
                tag_len  = '0;
                tag_hit  = 1'b1;
                endp_hit = 1'b1;
            end
            if (tag_len < SHORT_TAG_LEN) begin
                tag_hit  = tag_hit && (b == BR_TAG[tag_len]);
                endp_hit = endp_hit && (b == ENDP_TAG[tag_len]);
            end else begin
                tag_hit  = 1'b0;
                endp_hit = 1'b0;
            end
            if (tag_len < COUNT_MAX)
                tag_len++;
            if (tag_len == SHORT_TAG_LEN && tag_hit) begin
                drop_tag();
                text_q.push_back('{CHAR_NL, 1'b0});
                return;
            end
            if (tag_len == SHORT_TAG_LEN && endp_hit) begin
                drop_tag();
                phase = PH_DONE;
                text_q.push_back('{CHAR_NUL, 1'b1});
                return;
            end
            if (b == CHAR_GT)
                drop_tag();
        endfunction

        function void take_byte(logic [7:0] b, logic fresh);
            if (fresh) begin
                phase = PH_DIV;
                drop_tag();
            end
            if (b == CHAR_NL)
                return;
            case (phase)
                PH_DIV:  seek_tag(b, DIV_TAG);
                PH_P:    seek_tag(b, P_TAG);
                PH_TEXT: scan_text(b);
                default: ;
            endcase
        endfunction

        function void check_text(logic [7:0] b, logic last);
            text_item_t want;
            if (text_q.size() == 0) begin
                $display("%0t: unexpected result, actual byte %02h end %0b", $time, b, last);
                errors++;
                return;
            end
            want = text_q.pop_front();
            if (b !== want.text_byte) begin
                $display("%0t: text_byte mismatch, expected %02h, actual %02h",
                         $time, want.text_byte, b);
                errors++;
            end
            if (last !== want.text_end) begin
                $display("%0t: text_end mismatch, expected %0b, actual %0b",
                         $time, want.text_end, last);
                errors++;
            end
        endfunction
    endclass

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_doc_byte  = 8'h00;
    logic       s_doc_start = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_text_byte;
    logic       m_text_end;

    extract_scoreboard sb = new();

    // Idle rates in percent, and the length of a forced receiver hold-off.
    int unsigned tx_idle_pct  = 13;
    int unsigned rx_idle_pct  = 82;
    int unsigned rx_hold_left = 0;
    int unsigned n_accepted   = 0;

    // Random restarts in the middle of a document are allowed while set.
    bit          mid_restart  = 1'b1;

    // Bytes of the document that is about to be sent.
    logic [7:0] doc_bytes[$];

    html_tagged_text_extractor u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_doc_byte  (s_doc_byte),
        .s_doc_start (s_doc_start),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_byte (m_text_byte),
        .m_text_end  (m_text_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Both channels are observed at the clock edge, before any of the
    // nonblocking updates of that edge land, so the values seen here are
    // exactly the ones the block saw.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.take_byte(s_doc_byte, s_doc_start);
                n_accepted++;
            end
            if (m_valid && m_ready)
                sb.check_text(m_text_byte, m_text_end);
        end
    end

    // The receiver runs in its own process. A hold-off request keeps m_ready
    // low for that many cycles while the sender goes on offering bytes.
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (rx_hold_left != 0) begin
                m_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Pushes the characters of a tag. The character at position flip, if
    // any, is replaced by a random byte. A stray newline may slip in
    // anywhere; the block must skip it.
    function automatic void push_chars(string s, int flip);
        for (int i = 0; i < s.len(); i++) begin
            if ($urandom_range(39) == 0)
                doc_bytes.push_back(CHAR_NL);
            if (i == flip)
                doc_bytes.push_back(8'($urandom_range(255)));
            else
                doc_bytes.push_back(s[i]);
        end
    endfunction

    // Random bytes over the whole range. Without allow_lt no tag is opened.
    function automatic void push_plain(int n, bit allow_lt);
        logic [7:0] v;
        repeat (n) begin
            v = 8'($urandom_range(255));
            if (!allow_lt && v == CHAR_LT)
                v = v + 8'd1;
            doc_bytes.push_back(v);
        end
    endfunction

    // A tag made of n random lower case letters.
    function automatic void push_word_tag(int n);
        doc_bytes.push_back(CHAR_LT);
        repeat (n) doc_bytes.push_back(8'($urandom_range("z", "a")));
        doc_bytes.push_back(CHAR_GT);
    endfunction

    // Something that must not be taken for the searched tag: a damaged copy,
    // a cut-short copy, a copy that runs past the tag length (so the byte
    // that overflows it is dropped), a random tag, or plain bytes.
    function automatic void push_seek_decoy(string target);
        case ($urandom_range(4))
            0: push_chars(target, $urandom_range(target.len() - 1, 1));
            1: begin
                push_chars(target.substr(0, $urandom_range(target.len() - 3, 0)), -1);
                doc_bytes.push_back(CHAR_GT);
            end
            2: begin
                push_chars(target.substr(0, target.len() - 2), -1);
                repeat ($urandom_range(8, 1))
                    doc_bytes.push_back(8'($urandom_range("z", "a")));
                doc_bytes.push_back(CHAR_GT);
            end
            3: push_word_tag($urandom_range(30, 1));
            default: push_plain($urandom_range(6, 1), 1'b0);
        endcase
    endfunction

    // One piece of paragraph content.
    function automatic void push_text_piece();
        case ($urandom_range(9))
            0, 1, 2, 3: push_plain($urandom_range(8, 1), 1'b0);
            4: push_chars(BR_TAG, -1);
            5: push_chars(($urandom_range(1) != 0) ? BR_TAG : ENDP_TAG, $urandom_range(3, 1));
            6: push_word_tag($urandom_range(4, 1));
            // Mostly long enough for the tag length to saturate.
            7: push_word_tag($urandom_range(45, 28));
            8: push_chars("</pre>", -1);
            default: push_plain(1, 1'b1);
        endcase
    endfunction

    // Mostly well-formed documents with random content; some never find the
    // division or the paragraph, and some end without a closing tag.
    function automatic void make_document();
        repeat ($urandom_range(3)) push_seek_decoy(DIV_TAG);
        if ($urandom_range(9) != 0) begin
            push_chars(DIV_TAG, -1);
            repeat ($urandom_range(2)) push_seek_decoy(P_TAG);
            if ($urandom_range(9) != 0)
                push_chars(P_TAG, -1);
        end
        repeat ($urandom_range(12, 3)) push_text_piece();
        if ($urandom_range(4) != 0)
            push_chars(ENDP_TAG, -1);
        push_plain($urandom_range(4), 1'b1);
    endfunction

    // Offers one byte and returns at the edge where it is accepted. Valid is
    // only ever lowered for an idle cycle, never between back-to-back bytes.
    task automatic send_byte(input logic [7:0] b, input logic fresh);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_doc_byte  <= b;
        s_doc_start <= fresh;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Sends the queued bytes. A new document is marked on its first byte,
    // and now and then a restart falls in the middle of one.
    task automatic send_document(input bit fresh);
        for (int i = 0; i < doc_bytes.size(); i++)
            send_byte(doc_bytes[i], (fresh && i == 0) ||
                      (mid_restart && $urandom_range(199) == 0));
        doc_bytes.delete();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed document: the division and paragraph tags, the lowest and
        // highest byte values as text, a skipped newline, a line break, the
        // closing paragraph tag, and a byte in the done phase that must be
        // ignored.
        push_chars(DIV_TAG, -1);
        push_chars(P_TAG, -1);
        doc_bytes.push_back(8'h00);
        doc_bytes.push_back(8'hFF);
        doc_bytes.push_back(CHAR_NL);
        push_chars(BR_TAG, -1);
        push_chars(ENDP_TAG, -1);
        doc_bytes.push_back("q");
        send_document(1'b1);

        // Sender mostly busy, receiver mostly stalled.
        while (n_accepted < 150) begin
            make_document();
            send_document(1'b1);
        end

        // The other way round.
        tx_idle_pct = 82;
        rx_idle_pct = 13;
        while (n_accepted < 300) begin
            make_document();
            send_document(1'b1);
        end

        // No idling from here on. First the receiver holds off through a
        // long paragraph, so the output register fills and s_ready drops
        // while bytes keep coming. Then the sender waits until every
        // result has arrived. No restart may cut this paragraph short.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        mid_restart = 1'b0;
        push_chars(DIV_TAG, -1);
        push_chars(P_TAG, -1);
        send_document(1'b1);
        rx_hold_left = 200;
        push_plain(40, 1'b0);
        push_chars(ENDP_TAG, -1);
        send_document(1'b0);
        wait_drained();
        @(posedge aclk);
        mid_restart = 1'b1;

        while (n_accepted < 450) begin
            make_document();
            send_document(1'b1);
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("html_tagged_text_extractor_test: done, clean");
        end else begin
            $display("html_tagged_text_extractor_test: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("html_tagged_text_extractor_test: done, errors");
        $finish;
    end

endmodule
